// ----- rtl/e1b_pkg.sv -----
// Shared types, constants and the span slot lookup function of the ETC1S to BC1 block transcoder.
package e1b_pkg;

    localparam int EP_DEPTH    = 2560;
    localparam int IDX_DEPTH   = 80;
    localparam int EP_WIDTH    = 22;
    localparam int IDX_WIDTH   = 8;
    localparam int EP_AW       = $clog2(EP_DEPTH);
    localparam int IDX_AW      = $clog2(IDX_DEPTH);
    localparam int ROWS        = 4;
    localparam int ROW_TEXELS  = 4;

    localparam logic KIND_LOAD      = 1'b0;
    localparam logic KIND_BLOCK     = 1'b1;
    localparam logic TSEL_ENDPOINT  = 1'b0;
    localparam logic TSEL_INDEX     = 1'b1;

    typedef struct packed {
        logic [1:0] lo;
        logic [1:0] hi;
    } t_span;

    // lexicographic slot over (min, max)
    function automatic logic [3:0] span_slot(input logic [1:0] lo, input logic [1:0] hi);
        logic [3:0] slot;
        case ({lo, hi})
            4'b00_00: slot = 4'd0;
            4'b00_01: slot = 4'd1;
            4'b00_10: slot = 4'd2;
            4'b00_11: slot = 4'd3;
            4'b01_01: slot = 4'd4;
            4'b01_10: slot = 4'd5;
            4'b01_11: slot = 4'd6;
            4'b10_10: slot = 4'd7;
            4'b10_11: slot = 4'd8;
            4'b11_11: slot = 4'd9;
            default:  slot = 4'd0;
        endcase
        return slot;
    endfunction

endpackage

// ----- rtl/e1b_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module e1b_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 80
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/e1b_span_lane.sv -----
// Selector span lane: minimum and maximum selector of one block row.
module e1b_span_lane (
    input  logic              [7:0] i_row,
    output e1b_pkg::t_span          o_span
);

    always_comb begin
        logic [1:0] s;
        o_span.lo = 2'd3;
        o_span.hi = 2'd0;
        for (int x = 0; x < e1b_pkg::ROW_TEXELS; x++) begin
            s = i_row[2*x +: 2];
            if (s < o_span.lo) begin
                o_span.lo = s;
            end
            if (s > o_span.hi) begin
                o_span.hi = s;
            end
        end
    end

endmodule

// ----- rtl/e1b_row_map.sv -----
// Index map lane: maps the selectors of one row to a BC1 index byte.
module e1b_row_map (
    input  logic [7:0]                     i_row,
    input  logic [e1b_pkg::IDX_WIDTH-1:0]  i_imap,
    input  logic                           i_four_colour,
    output logic [7:0]                     o_byte
);

    always_comb begin
        o_byte = '0;
        for (int x = 0; x < e1b_pkg::ROW_TEXELS; x++) begin
            o_byte[2*x +: 2] = i_four_colour ? i_imap[2*i_row[2*x +: 2] +: 2] : 2'd0;
        end
    end

endmodule

// ----- rtl/etc1s_to_bc1_block_transcoder.sv -----
// Top level of the ETC1S to BC1 block transcoder: lanes, table RAMs and output stage.
//
//   channel   direction  handshake            payload
//   request   in         i_valid / o_stall    i_kind .. i_selector_rows
//   result    out        o_valid / i_stall    o_colour_endpoints, o_texel_indices
//
// One request per cycle while o_stall is low.
// Load requests write the tables at acceptance and produce no result.
// A block passes the span register stage, the registered table RAM reads
// (three endpoint copies and one index copy) and the output register.
// Reset clears the stage valid bits only; table contents stay undefined until loaded.
// Each stage advances when empty or when the stage after it advances; o_stall rises
// only when every stage holds a block.
module etc1s_to_bc1_block_transcoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic        i_table_select,
    input  logic [11:0] i_table_address,
    input  logic [21:0] i_table_data,
    input  logic [4:0]  i_base_red,
    input  logic [4:0]  i_base_green,
    input  logic [4:0]  i_base_blue,
    input  logic [2:0]  i_intensity,
    input  logic [31:0] i_selector_rows,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_colour_endpoints,
    output logic [31:0] o_texel_indices
);

    localparam int EPW = e1b_pkg::EP_WIDTH;
    localparam int EPA = e1b_pkg::EP_AW;
    localparam int IXA = e1b_pkg::IDX_AW;

    logic en_a, en_b, en_out;
    logic accept, ep_we, idx_we;

    e1b_pkg::t_span lane_span [e1b_pkg::ROWS];
    e1b_pkg::t_span r_a_span  [e1b_pkg::ROWS];
    logic           r_a_v;
    logic [4:0]     r_a_red, r_a_green, r_a_blue;
    logic [2:0]     r_a_inten;
    logic [31:0]    r_a_rows;

    logic           r_b_v;
    logic [31:0]    r_b_rows;

    logic           r_out_v;
    logic [31:0]    r_out_colour, r_out_idx;

    logic [1:0]     s_lo, s_hi;
    logic [3:0]     s_slot;
    logic [EPA-1:0] addr_red, addr_green, addr_blue;
    logic [IXA-1:0] addr_idx;
    logic [EPW-1:0] rd_red, rd_green, rd_blue;
    logic [e1b_pkg::IDX_WIDTH-1:0] rd_imap;
    logic [15:0]    c0, c1;
    logic           four_colour;
    logic [31:0]    n_idx;

    assign en_out = !r_out_v || !i_stall;
    assign en_b   = !r_b_v || en_out;
    assign en_a   = !r_a_v || en_b;
    assign o_stall = !en_a;
    assign accept  = i_valid && en_a;

    assign ep_we  = accept && (i_kind == e1b_pkg::KIND_LOAD)
                    && (i_table_select == e1b_pkg::TSEL_ENDPOINT)
                    && (i_table_address < 12'(e1b_pkg::EP_DEPTH));
    assign idx_we = accept && (i_kind == e1b_pkg::KIND_LOAD)
                    && (i_table_select == e1b_pkg::TSEL_INDEX)
                    && (i_table_address < 12'(e1b_pkg::IDX_DEPTH));

    for (genvar g = 0; g < e1b_pkg::ROWS; g++) begin : g_span
        e1b_span_lane u_lane (
            .i_row  (i_selector_rows[8*g +: 8]),
            .o_span (lane_span[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_v <= accept && (i_kind == e1b_pkg::KIND_BLOCK);
            end
            if (en_b) begin
                r_b_v <= r_a_v;
            end
            if (en_out) begin
                r_out_v <= r_b_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_span  <= lane_span;
            r_a_red   <= i_base_red;
            r_a_green <= i_base_green;
            r_a_blue  <= i_base_blue;
            r_a_inten <= i_intensity;
            r_a_rows  <= i_selector_rows;
        end
        if (en_b) begin
            r_b_rows <= r_a_rows;
        end
        if (en_out) begin
            r_out_colour <= {c1, c0};
            r_out_idx    <= n_idx;
        end
    end

    // merge the row spans into the block span
    always_comb begin
        s_lo = r_a_span[0].lo;
        s_hi = r_a_span[0].hi;
        for (int r = 1; r < e1b_pkg::ROWS; r++) begin
            if (r_a_span[r].lo < s_lo) begin
                s_lo = r_a_span[r].lo;
            end
            if (r_a_span[r].hi > s_hi) begin
                s_hi = r_a_span[r].hi;
            end
        end
        s_slot = e1b_pkg::span_slot(s_lo, s_hi);
    end

    function automatic logic [EPA-1:0] ep_addr(input logic [4:0] base, input logic [2:0] inten,
                                               input logic [3:0] slot);
        logic [7:0] row;
        row = {base, inten};
        return EPA'({1'b0, row, 3'b000}) + EPA'({3'b000, row, 1'b0}) + EPA'(slot);
    endfunction

    assign addr_red   = ep_addr(r_a_red, r_a_inten, s_slot);
    assign addr_green = ep_addr(r_a_green, r_a_inten, s_slot);
    assign addr_blue  = ep_addr(r_a_blue, r_a_inten, s_slot);
    assign addr_idx   = IXA'({r_a_inten, 3'b000}) + IXA'({r_a_inten, 1'b0}) + IXA'(s_slot);

    e1b_ram #(.P_WIDTH(EPW), .P_DEPTH(e1b_pkg::EP_DEPTH)) u_ep_red (
        .i_clk   (i_clk),
        .i_we    (ep_we),
        .i_waddr (i_table_address[EPA-1:0]),
        .i_wdata (i_table_data),
        .i_re    (en_b),
        .i_raddr (addr_red),
        .o_rdata (rd_red)
    );

    e1b_ram #(.P_WIDTH(EPW), .P_DEPTH(e1b_pkg::EP_DEPTH)) u_ep_green (
        .i_clk   (i_clk),
        .i_we    (ep_we),
        .i_waddr (i_table_address[EPA-1:0]),
        .i_wdata (i_table_data),
        .i_re    (en_b),
        .i_raddr (addr_green),
        .o_rdata (rd_green)
    );

    e1b_ram #(.P_WIDTH(EPW), .P_DEPTH(e1b_pkg::EP_DEPTH)) u_ep_blue (
        .i_clk   (i_clk),
        .i_we    (ep_we),
        .i_waddr (i_table_address[EPA-1:0]),
        .i_wdata (i_table_data),
        .i_re    (en_b),
        .i_raddr (addr_blue),
        .o_rdata (rd_blue)
    );

    e1b_ram #(.P_WIDTH(e1b_pkg::IDX_WIDTH), .P_DEPTH(e1b_pkg::IDX_DEPTH)) u_idx (
        .i_clk   (i_clk),
        .i_we    (idx_we),
        .i_waddr (i_table_address[IXA-1:0]),
        .i_wdata (i_table_data[e1b_pkg::IDX_WIDTH-1:0]),
        .i_re    (en_b),
        .i_raddr (addr_idx),
        .o_rdata (rd_imap)
    );

    assign c0 = {rd_red[9:5], rd_green[21:16], rd_blue[9:5]};
    assign c1 = {rd_red[4:0], rd_green[15:10], rd_blue[4:0]};
    assign four_colour = c0 > c1;

    for (genvar g = 0; g < e1b_pkg::ROWS; g++) begin : g_map
        e1b_row_map u_map (
            .i_row         (r_b_rows[8*g +: 8]),
            .i_imap        (rd_imap),
            .i_four_colour (four_colour),
            .o_byte        (n_idx[8*g +: 8])
        );
    end

    assign o_valid            = r_out_v;
    assign o_colour_endpoints = r_out_colour;
    assign o_texel_indices    = r_out_idx;

    a_no_write_under_pending_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ep_we || idx_we) |-> (!r_a_v || en_b))
        else $error("table write while a block waits for its read");

    a_read_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_v && !en_out) |=> (r_b_v && $stable(rd_red) && $stable(rd_green)
                                && $stable(rd_blue) && $stable(rd_imap)))
        else $error("table read data lost while stalled");

    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_v |-> (s_lo <= s_hi))
        else $error("merged span minimum above maximum");

    a_three_colour_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_colour_endpoints[15:0] > o_colour_endpoints[31:16])
                     || (o_texel_indices == 32'd0)))
        else $error("nonzero indices in three-colour block");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_a_v && r_b_v && r_out_v && i_stall))
        else $error("request stalled with a free stage");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the ETC1S to BC1 block transcoder.
module tb_top;
    import e1b_pkg::*;

    localparam int SPAN_SLOTS    = 10;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int IDLE_LIMIT    = 1000;
    localparam int DRAIN_CYCLES  = 12;

    class bc1_transcode_mirror;
        logic [21:0] endpoint_mem [EP_DEPTH];
        logic [7:0]  index_mem [IDX_DEPTH];
        logic [31:0] due_endpoints [$];
        logic [31:0] due_indices [$];
        int          faults = 0;

        function int slot_of(input logic [31:0] rows);
            logic [1:0] lo, hi, s;
            int         first;
            int         i;
            lo = 2'd3;
            hi = 2'd0;
            for (i = 0; i < 16; i++) begin
                s = rows[2*i +: 2];
                if (s < lo) lo = s;
                if (s > hi) hi = s;
            end
            case (lo)
                2'd0: first = 0;
                2'd1: first = 4;
                2'd2: first = 7;
                default: first = 9;
            endcase
            return first + int'(hi) - int'(lo);
        endfunction

        function int ep_addr(input logic [4:0] base, input logic [2:0] inten, input int slot);
            return (int'(base) * 8 + int'(inten)) * SPAN_SLOTS + slot;
        endfunction

        function int pending();
            return due_endpoints.size();
        endfunction

        function void absorb_request(input logic kind, input logic tsel,
                                     input logic [11:0] addr, input logic [21:0] data,
                                     input logic [4:0] br, bg, bb,
                                     input logic [2:0] inten, input logic [31:0] rows);
            int          slot;
            int          i;
            logic [21:0] er, eg, eb;
            logic [15:0] c0, c1;
            logic [7:0]  imap;
            logic [31:0] idx;
            logic [1:0]  s;
            if (kind == KIND_LOAD) begin
                if (tsel == TSEL_ENDPOINT) begin
                    if (addr < EP_DEPTH) endpoint_mem[addr] = data;
                end else if (addr < IDX_DEPTH) begin
                    index_mem[addr] = data[7:0];
                end
                return;
            end
            slot = slot_of(rows);
            er = endpoint_mem[ep_addr(br, inten, slot)];
            eg = endpoint_mem[ep_addr(bg, inten, slot)];
            eb = endpoint_mem[ep_addr(bb, inten, slot)];
            c0 = {er[9:5], eg[21:16], eb[9:5]};
            c1 = {er[4:0], eg[15:10], eb[4:0]};
            idx = '0;
            if (c0 > c1) begin
                imap = index_mem[int'(inten) * SPAN_SLOTS + slot];
                for (i = 0; i < 16; i++) begin
                    s = rows[2*i +: 2];
                    idx[2*i +: 2] = imap[2*s +: 2];
                end
            end
            due_endpoints.push_back({c1, c0});
            due_indices.push_back(idx);
        endfunction

        function void compare_block(input logic [31:0] endpoints, input logic [31:0] indices);
            logic [31:0] want_ep, want_ix;
            if (due_endpoints.size() == 0) begin
                $display("%0t: unexpected block result endpoints %h indices %h",
                         $time, endpoints, indices);
                faults++;
                return;
            end
            want_ep = due_endpoints.pop_front();
            want_ix = due_indices.pop_front();
            if (endpoints !== want_ep) begin
                $display("%0t: colour_endpoints expected %h actual %h",
                         $time, want_ep, endpoints);
                faults++;
            end
            if (indices !== want_ix) begin
                $display("%0t: texel_indices expected %h actual %h",
                         $time, want_ix, indices);
                faults++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_kind = KIND_LOAD;
    logic        i_table_select = TSEL_ENDPOINT;
    logic [11:0] i_table_address = '0;
    logic [21:0] i_table_data = '0;
    logic [4:0]  i_base_red = '0;
    logic [4:0]  i_base_green = '0;
    logic [4:0]  i_base_blue = '0;
    logic [2:0]  i_intensity = '0;
    logic [31:0] i_selector_rows = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_colour_endpoints;
    logic [31:0] o_texel_indices;

    bc1_transcode_mirror mirror = new();

    bit ep_written [EP_DEPTH];
    bit idx_written [IDX_DEPTH];
    int useful_sent = 0;
    bit calm = 1'b0;
    int idle_cycles = 0;
    int stall_left = 0;
    int free_left = 0;

    etc1s_to_bc1_block_transcoder uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_kind             (i_kind),
        .i_table_select     (i_table_select),
        .i_table_address    (i_table_address),
        .i_table_data       (i_table_data),
        .i_base_red         (i_base_red),
        .i_base_green       (i_base_green),
        .i_base_blue        (i_base_blue),
        .i_intensity        (i_intensity),
        .i_selector_rows    (i_selector_rows),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_colour_endpoints (o_colour_endpoints),
        .o_texel_indices    (o_texel_indices)
    );

    always #4 i_clk = ~i_clk;

    function automatic int pause_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] make_rows(input int lo, input int hi);
        logic [31:0] rows;
        int          i, a, b;
        for (i = 0; i < 16; i++) rows[2*i +: 2] = 2'($urandom_range(lo, hi));
        a = $urandom_range(0, 15);
        b = (a + $urandom_range(1, 15)) % 16;
        rows[2*a +: 2] = 2'(lo);
        rows[2*b +: 2] = 2'(hi);
        return rows;
    endfunction

    // stall the result side in random runs
    always @(posedge i_clk) begin
        if (free_left == 0 && stall_left == 0) begin
            free_left = calm ? 64 : $urandom_range(1, 12);
            stall_left = calm ? 0 : pause_len();
        end
        if (free_left > 0) begin
            free_left--;
            i_stall <= 1'b0;
        end else begin
            stall_left--;
            i_stall <= 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (i_rst_n && o_valid && !i_stall)
            mirror.compare_block(o_colour_endpoints, o_texel_indices);
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("etc1s_to_bc1_block_transcoder verification failed");
        $finish;
    end

    task automatic send_request(input logic kind, input logic tsel,
                                input logic [11:0] addr, input logic [21:0] data,
                                input logic [4:0] br, bg, bb,
                                input logic [2:0] inten, input logic [31:0] rows);
        int gap;
        gap = calm ? 0 : pause_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_kind          <= kind;
        i_table_select  <= tsel;
        i_table_address <= addr;
        i_table_data    <= data;
        i_base_red      <= br;
        i_base_green    <= bg;
        i_base_blue     <= bb;
        i_intensity     <= inten;
        i_selector_rows <= rows;
        do @(negedge i_clk); while (o_stall);
        mirror.absorb_request(kind, tsel, addr, data, br, bg, bb, inten, rows);
        @(posedge i_clk);
    endtask

    task automatic load_table(input logic tsel, input logic [11:0] addr,
                              input logic [21:0] data);
        if (tsel == TSEL_ENDPOINT && addr < EP_DEPTH) begin
            ep_written[addr] = 1'b1;
            useful_sent++;
        end else if (tsel == TSEL_INDEX && addr < IDX_DEPTH) begin
            idx_written[addr] = 1'b1;
            useful_sent++;
        end
        send_request(KIND_LOAD, tsel, addr, data,
                     5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                     5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)), $urandom());
    endtask

    // fill any entry the block reads that holds nothing yet, then send the block
    task automatic transcode(input logic [4:0] br, bg, bb,
                             input logic [2:0] inten, input logic [31:0] rows);
        logic [4:0] trio [3];
        int         slot, a, k;
        trio[0] = br;
        trio[1] = bg;
        trio[2] = bb;
        slot = mirror.slot_of(rows);
        for (k = 0; k < 3; k++) begin
            a = mirror.ep_addr(trio[k], inten, slot);
            if (!ep_written[a]) load_table(TSEL_ENDPOINT, 12'(a), 22'($urandom()));
        end
        a = int'(inten) * SPAN_SLOTS + slot;
        if (!idx_written[a]) load_table(TSEL_INDEX, 12'(a), 22'($urandom()));
        useful_sent++;
        send_request(KIND_BLOCK, 1'($urandom_range(0, 1)), 12'($urandom()),
                     22'($urandom()), br, bg, bb, inten, rows);
    endtask

    initial begin : stimulus
        int          directed_end, pick, lo, hi, slot;
        logic [4:0]  br, bg, bb;
        logic [2:0]  inten;
        logic [31:0] rows;
        bit          from_pool;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_table(TSEL_ENDPOINT, 12'd0, 22'h3F03E0);
        load_table(TSEL_INDEX, 12'd0, 22'h3FFF1B);
        transcode(5'd0, 5'd0, 5'd0, 3'd0, 32'h0000_0000);
        load_table(TSEL_ENDPOINT, 12'd2559, 22'h3FFFFF);
        load_table(TSEL_INDEX, 12'd79, 22'h0000E4);
        transcode(5'd31, 5'd31, 5'd31, 3'd7, 32'hFFFF_FFFF);
        load_table(TSEL_ENDPOINT, 12'd2560, 22'h000000);
        load_table(TSEL_ENDPOINT, 12'd4095, 22'h000000);
        load_table(TSEL_INDEX, 12'd80, 22'h000000);
        load_table(TSEL_INDEX, 12'd128, 22'h000000);
        load_table(TSEL_INDEX, 12'd4095, 22'h000000);
        transcode(5'd0, 5'd0, 5'd0, 3'd0, 32'h0000_0000);
        transcode(5'd31, 5'd31, 5'd31, 3'd7, 32'hFFFF_FFFF);
        load_table(TSEL_ENDPOINT, 12'd0, 22'h00FC1F);
        transcode(5'd0, 5'd0, 5'd0, 3'd0, 32'h0000_0000);

        directed_end = useful_sent;
        while (useful_sent < directed_end + RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) == 0) calm = !calm;
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                from_pool = ($urandom_range(0, 1) == 1);
                br = from_pool ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
                bg = from_pool ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
                bb = from_pool ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
                inten = 3'($urandom_range(0, 7));
                lo = $urandom_range(0, 3);
                hi = $urandom_range(lo, 3);
                rows = ($urandom_range(0, 9) == 0) ? $urandom() : make_rows(lo, hi);
                if ($urandom_range(0, 4) == 0) begin
                    slot = mirror.slot_of(rows);
                    load_table(TSEL_ENDPOINT, 12'(mirror.ep_addr(br, inten, slot)),
                               22'($urandom()));
                end
                transcode(br, bg, bb, inten, rows);
            end else if (pick < 87) begin
                load_table(TSEL_ENDPOINT,
                           ($urandom_range(0, 1) == 1) ? 12'($urandom_range(0, 319))
                                                       : 12'($urandom_range(0, 2559)),
                           22'($urandom()));
            end else if (pick < 95) begin
                load_table(TSEL_INDEX, 12'($urandom_range(0, 79)), 22'($urandom()));
            end else if ($urandom_range(0, 1) == 1) begin
                load_table(TSEL_ENDPOINT, 12'($urandom_range(2560, 4095)), 22'($urandom()));
            end else begin
                load_table(TSEL_INDEX, 12'($urandom_range(80, 4095)), 22'($urandom()));
            end
        end

        i_valid <= 1'b0;
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mirror.faults == 0) begin
            $display("etc1s_to_bc1_block_transcoder verification clean");
        end else begin
            $display("etc1s_to_bc1_block_transcoder verification failed");
        end
        $finish;
    end
endmodule
